// File: rtl/core/mset_pkg.sv
package mset_pkg;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_CREATE  = 2'd1,
		OP_DESTROY = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_CREATE  = 2'd0,
		KIND_EXPIRY  = 2'd1,
		KIND_DESTROY = 2'd2,
		KIND_QUERY   = 2'd3
	} kind_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_UNUSED  = 2'd2;

	localparam int RES_CAP = 16;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  slot;
		logic [31:0] period;
		logic        periodic;
		logic [15:0] tag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        slot_out;
		logic [15:0]       tag_out;
		logic signed [31:0] remaining;
		logic [1:0]        status;
		logic              last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item
		logic tick;      // advance now
		logic alloc;     // write new slot, start insert
		logic ins_start; // begin sorted insert of cur slot
		logic ins_step;  // compare at scan position, advance
		logic ins_place; // shift list and place at scan position
		logic rm_start;  // begin search for slot to remove
		logic rm_step;   // advance search / shift
		logic pop;       // remove head, latch it as cur slot
		logic free_slot; // clear in-use of input slot
		logic emit;      // drive result
		logic emit_last;
		logic [1:0] emit_sel; // which result kind
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic list_empty;
		logic list_full;
		logic head_due;
		logic ins_found;  // insert position reached
		logic rm_done;    // removal shift finished or not found
		logic cur_reload;
		logic in_used;    // input slot valid and in use
		logic any_free;
	} dp_stat_t;

endpackage

// File: rtl/core/mset_ctrl.sv
module mset_ctrl import mset_pkg::*; #(
	parameter int EV_CAP = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic [1:0] op,
	output logic     busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_CREATE, S_INS, S_INS_PLACE, S_RM, S_DESTROY_OUT,
		S_TICK_CHECK, S_POP, S_EMIT_EXP
	} state_t;

	localparam int CW = $clog2(EV_CAP + 1);

	state_t state_q;
	logic [CW-1:0] nexp_q;
	logic ins_from_tick_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_DECODE: begin
				case (op)
					OP_TICK: cmd.tick = 1'b1;
					OP_CREATE: begin
						if (stat.any_free) begin
							cmd.alloc = 1'b1;
							cmd.ins_start = 1'b1;
						end else begin
							cmd.emit = 1'b1;
							cmd.emit_last = 1'b1;
							cmd.emit_sel = KIND_CREATE;
						end
					end
					OP_DESTROY: begin
						if (stat.in_used) begin
							cmd.rm_start = 1'b1;
						end else begin
							cmd.emit = 1'b1;
							cmd.emit_last = 1'b1;
							cmd.emit_sel = KIND_DESTROY;
						end
					end
					default: begin
						cmd.emit = 1'b1;
						cmd.emit_last = 1'b1;
						cmd.emit_sel = KIND_QUERY;
					end
				endcase
			end
			S_INS: cmd.ins_step = !stat.ins_found;
			S_INS_PLACE: begin
				cmd.ins_place = 1'b1;
				if (!ins_from_tick_q) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_sel = KIND_CREATE;
				end
			end
			S_RM: cmd.rm_step = 1'b1;
			S_DESTROY_OUT: begin
				cmd.free_slot = 1'b1;
				cmd.emit = 1'b1;
				cmd.emit_last = 1'b1;
				cmd.emit_sel = KIND_DESTROY;
			end
			S_POP: cmd.pop = 1'b1;
			S_EMIT_EXP: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = KIND_EXPIRY;
				cmd.ins_start = stat.cur_reload && !stat.list_full;
			end
			default: ;
		endcase
	end

	// last flag on an expiry event needs the next head decision; the
	// datapath looks ahead for it, see mset_dp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nexp_q <= '0;
			ins_from_tick_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_DECODE;
				S_DECODE: begin
					case (op)
						OP_TICK: begin
							nexp_q <= '0;
							state_q <= S_TICK_CHECK;
						end
						OP_CREATE: begin
							ins_from_tick_q <= 1'b0;
							state_q <= stat.any_free ?
								(stat.list_full ? S_INS_PLACE : S_INS) : S_IDLE;
						end
						OP_DESTROY: state_q <= stat.in_used ? S_RM : S_IDLE;
						default: state_q <= S_IDLE;
					endcase
				end
				S_INS: if (stat.ins_found) state_q <= S_INS_PLACE;
				S_INS_PLACE: state_q <= ins_from_tick_q ? S_TICK_CHECK : S_IDLE;
				S_RM: if (stat.rm_done) state_q <= S_DESTROY_OUT;
				S_DESTROY_OUT: state_q <= S_IDLE;
				S_TICK_CHECK: begin
					if (nexp_q != CW'(EV_CAP) && !stat.list_empty && stat.head_due)
						state_q <= S_POP;
					else
						state_q <= S_IDLE;
				end
				S_POP: state_q <= S_EMIT_EXP;
				S_EMIT_EXP: begin
					nexp_q <= nexp_q + 1'b1;
					ins_from_tick_q <= 1'b1;
					if (stat.cur_reload && !stat.list_full)
						state_q <= S_INS;
					else
						state_q <= S_TICK_CHECK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/mset_dp.sv
module mset_dp import mset_pkg::*; #(
	parameter int NUM_TIMERS = 16,
	parameter int TAG_WIDTH  = 16,
	parameter int EV_CAP     = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output logic      res_valid,
	output out_item_t res_item
);
	localparam int SW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int EW = $clog2(EV_CAP + 1);

	in_item_t       in_q;
	logic [31:0]    now_q;
	logic [NUM_TIMERS-1:0] used_q;
	logic [31:0]    exp_q  [NUM_TIMERS];
	logic [31:0]    per_q  [NUM_TIMERS];
	logic           rel_q  [NUM_TIMERS];
	logic [TAG_WIDTH-1:0] tag_q [NUM_TIMERS];
	logic [SW-1:0]  list_q [NUM_TIMERS];
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  pos_q;
	logic [SW-1:0]  cur_q;
	logic [31:0]    key_q;
	logic [31:0]    cur_rem_q;
	logic [EW-1:0]  nev_q;
	logic           rm_found_q;

	logic [SW-1:0]  free_idx;
	logic           any_free;
	logic [31:0]    eff_per;
	logic           in_used;
	logic [SW-1:0]  in_slot;
	logic [SW-1:0]  head;
	logic [31:0]    hdiff, idiff;
	logic [SW-1:0]  pos_idx;
	logic           rm_hit;

	function automatic logic le0(input logic [31:0] d);
		return (d == 32'd0) || d[31];
	endfunction

	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign eff_per = (in_q.period == 32'd0) ? 32'd1 : in_q.period;
	assign in_slot = SW'(in_q.slot);
	assign in_used = (32'(in_q.slot) < NUM_TIMERS) && used_q[in_slot];
	assign head = list_q[0];
	assign hdiff = exp_q[head] - now_q;
	assign pos_idx = pos_q[SW-1:0];
	assign idiff = key_q - exp_q[list_q[pos_idx]];
	assign rm_hit = rm_found_q || (list_q[pos_idx] == in_slot);

	assign stat.list_empty = (cnt_q == '0);
	assign stat.list_full  = (cnt_q == CW'(NUM_TIMERS));
	assign stat.head_due   = le0(hdiff);
	assign stat.ins_found  = (pos_q >= cnt_q) || le0(idiff);
	assign stat.rm_done    = (pos_q >= cnt_q);
	assign stat.cur_reload = rel_q[cur_q];
	assign stat.in_used    = in_used;
	assign stat.any_free   = any_free;

	// last on an expiry: the next head check would stop the run
	logic exp_last;
	logic [SW-1:0] nhead;
	logic          reins;
	always_comb begin
		reins = rel_q[cur_q] && (cnt_q != CW'(NUM_TIMERS));
		nhead = head;
		exp_last = 1'b0;
		if (EW'(nev_q + 1'b1) == EW'(EV_CAP)) begin
			exp_last = 1'b1;
		end else if (cnt_q == '0) begin
			// only the reinserted entry could follow
			exp_last = !(reins && le0(per_q[cur_q]));
		end else begin
			// reinserted key goes before head if it is due-or-earlier
			if (reins && le0((now_q + per_q[cur_q]) - exp_q[head]))
				exp_last = !le0(per_q[cur_q]);
			else
				exp_last = !le0(exp_q[head] - now_q);
		end
	end

	out_item_t res_d;
	always_comb begin
		res_d = '0;
		res_d.kind = cmd.emit_sel;
		res_d.last = cmd.emit_last;
		case (cmd.emit_sel)
			KIND_CREATE: begin
				if (cmd.ins_place) begin
					res_d.slot_out = 4'(cur_q);
					res_d.remaining = per_q[cur_q];
					res_d.status = ST_OK;
				end else begin
					res_d.status = ST_NO_FREE;
				end
			end
			KIND_EXPIRY: begin
				res_d.slot_out = 4'(cur_q);
				res_d.tag_out = 16'(tag_q[cur_q]);
				res_d.remaining = cur_rem_q;
				res_d.last = exp_last;
			end
			KIND_DESTROY: begin
				res_d.slot_out = in_q.slot;
				res_d.status = in_used ? ST_OK : ST_UNUSED;
			end
			default: begin
				res_d.slot_out = in_q.slot;
				if (in_used) begin
					res_d.remaining = exp_q[in_slot] - now_q;
					res_d.status = ST_OK;
				end else begin
					res_d.remaining = 32'hFFFF_FFFF;
					res_d.status = ST_UNUSED;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			used_q <= '0;
			cnt_q <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= cmd.emit;
			if (cmd.tick) now_q <= now_q + 32'd1;
			if (cmd.alloc) used_q[free_idx] <= 1'b1;
			if (cmd.free_slot) used_q[in_slot] <= 1'b0;
			if (cmd.ins_place && cnt_q != CW'(NUM_TIMERS)) cnt_q <= cnt_q + 1'b1;
			if (cmd.pop) cnt_q <= cnt_q - 1'b1;
			// drop the entry on the final search step
			if (cmd.rm_step && pos_q < cnt_q && rm_hit && pos_q + 1'b1 >= cnt_q)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_item;
		if (cmd.tick) nev_q <= '0;
		if (cmd.emit && cmd.emit_sel == KIND_EXPIRY) nev_q <= nev_q + 1'b1;
		if (cmd.alloc) begin
			per_q[free_idx] <= eff_per;
			rel_q[free_idx] <= in_q.periodic;
			tag_q[free_idx] <= TAG_WIDTH'(in_q.tag);
			cur_q <= free_idx;
		end
		if (cmd.ins_start) begin
			pos_q <= '0;
			if (cmd.alloc) begin
				key_q <= now_q + eff_per;
				exp_q[free_idx] <= now_q + eff_per;
			end else begin
				key_q <= now_q + per_q[cur_q];
			end
		end
		if (cmd.ins_step) pos_q <= pos_q + 1'b1;
		if (cmd.ins_place && cnt_q != CW'(NUM_TIMERS)) begin
			exp_q[cur_q] <= key_q;
			for (int i = NUM_TIMERS - 1; i > 0; i--)
				if (CW'(i) > pos_q && CW'(i) <= cnt_q) list_q[i] <= list_q[i-1];
			list_q[pos_idx] <= cur_q;
		end
		if (cmd.rm_start) begin
			pos_q <= '0;
			rm_found_q <= 1'b0;
		end
		if (cmd.rm_step && pos_q < cnt_q) begin
			pos_q <= pos_q + 1'b1;
			if (rm_hit) begin
				rm_found_q <= 1'b1;
				if (32'(pos_q) + 1 < NUM_TIMERS && pos_q + 1'b1 < cnt_q)
					list_q[pos_idx] <= list_q[SW'(pos_q + 1'b1)];
			end
		end
		if (cmd.pop) begin
			cur_q <= head;
			cur_rem_q <= hdiff;
			for (int i = 0; i < NUM_TIMERS - 1; i++) list_q[i] <= list_q[i+1];
		end
		if (cmd.emit) res_item <= res_d;
	end
endmodule

// File: rtl/core/multi_slot_expiry_timer.sv
// Query and failed create or destroy reply straight from decode; otherwise create and
// destroy walk the sorted list, one list entry per cycle, then reply. Tick: each expiry
// is popped and emitted, and a periodic entry is reinserted by the same list walk;
// busy stays high until the item is done, and after a query, create or destroy the
// next item can start in the cycle its final reply shows. Results cannot be stalled.
// Reset clears now, slot usage and the list count; slot stores are unset.
module multi_slot_expiry_timer import mset_pkg::*; #(
	parameter int NUM_TIMERS = 16,
	parameter int TAG_WIDTH  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  in_item,
	output logic      busy,
	output logic      result_valid,
	output out_item_t result
);
	localparam int EV_CAP = (NUM_TIMERS < RES_CAP) ? NUM_TIMERS : RES_CAP;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) op_q <= OP_TICK;
		else if (start && !busy) op_q <= in_item.operation;
	end

	mset_ctrl #(.EV_CAP(EV_CAP)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op_q),
		.busy(busy), .stat(stat), .cmd(cmd)
	);

	mset_dp #(.NUM_TIMERS(NUM_TIMERS), .TAG_WIDTH(TAG_WIDTH), .EV_CAP(EV_CAP)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
		.res_valid(result_valid), .res_item(result)
	);

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy) else $error("load while busy");
	a_no_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid) else $error("result without work");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last && result.kind != KIND_EXPIRY) |-> !busy)
		else $error("busy after final reply");
endmodule
